@@ rtl/sag_pkg.sv @@
// ----------------------------------------------------------------------------
// sag_pkg: shared types and constants of the stencil address generator
// Field widths, neighbourhood and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sag_pkg;

    // Field widths
    localparam int ADDR_W   = 34;
    localparam int KIND_W   = 3;
    localparam int RADIUS_W = 6;
    localparam int ROWW_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 7;   // signed stencil offset
    localparam int CNT_W    = 15;  // exact point count for any radius

    // Address space wrap and default point limit
    localparam int ADDR_BITS      = 34;
    localparam int MAX_POINTS_DEF = 32;

    // Neighbourhood kinds
    localparam logic [KIND_W-1:0] KIND_VON_NEUMANN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOORE       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CROSS       = 3'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_CHECK,
        ST_FLAG,
        ST_WALK
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic cap;        // capture the request
        logic cnt;        // register the point count
        logic init_walk;  // set up the first offset and the points left
        logic step;       // handle the current offset and advance
        logic flag;       // load a single error or empty word
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic over;       // count exceeds the limit
        logic zero;       // count is zero
        logic out_free;   // output register can take a word
        logic skip;       // current offset is an excluded centre
        logic last_pt;    // one point left to emit
    } sts_t;

endpackage

@@ rtl/stencil_address_generator.sv @@
// ----------------------------------------------------------------------------
// stencil_address_generator: 2-D stencil gather address generator
// Sequence: a taken request is counted and range-checked, then either loads
// one error or empty word or walks its points. A new request is taken only
// after the last word of the previous one has been loaded.
// The walker visits the selected points, one per cycle, and steps over an
// excluded centre; a held output stalls the walk until the word is taken.
// Reset: synchronous active-low aresetn clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module stencil_address_generator #(
    parameter int MAX_POINTS = sag_pkg::MAX_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sag_pkg::ADDR_W-1:0]      s_base_addr,
    input  logic [sag_pkg::KIND_W-1:0]      s_nbhd_kind,
    input  logic                            s_center_incl,
    input  logic [sag_pkg::RADIUS_W-1:0]    s_radius,
    input  logic [sag_pkg::ROWW_W-1:0]      s_row_width,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sag_pkg::ADDR_W-1:0]      m_elem_addr,
    output logic [sag_pkg::STATUS_W-1:0]    m_status,
    output logic                            m_last
);

    sag_pkg::cmd_t cmd;
    sag_pkg::sts_t sts;

    // Sequencer
    sag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath
    sag_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_base_addr   (s_base_addr),
        .s_nbhd_kind   (s_nbhd_kind),
        .s_center_incl (s_center_incl),
        .s_radius      (s_radius),
        .s_row_width   (s_row_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_elem_addr   (m_elem_addr),
        .m_status      (m_status),
        .m_last        (m_last),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

@@ rtl/sag_ctrl.sv @@
// ----------------------------------------------------------------------------
// sag_ctrl: sequencer of the stencil address generator
// Steps one request through capture, counting, the range check and either a
// single flag word or the offset walk.
// ----------------------------------------------------------------------------
module sag_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sag_pkg::sts_t sts,
    output sag_pkg::cmd_t cmd
);

    sag_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sag_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sag_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sag_pkg::ST_COUNT;
                end
            end
            sag_pkg::ST_COUNT: begin
                state_next = sag_pkg::ST_CHECK;
            end
            sag_pkg::ST_CHECK: begin
                if (sts.over || sts.zero) begin
                    state_next = sag_pkg::ST_FLAG;
                end else begin
                    state_next = sag_pkg::ST_WALK;
                end
            end
            sag_pkg::ST_FLAG: begin
                if (sts.out_free) begin
                    state_next = sag_pkg::ST_IDLE;
                end
            end
            sag_pkg::ST_WALK: begin
                if (sts.out_free && !sts.skip && sts.last_pt) begin
                    state_next = sag_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sag_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        case (state_reg)
            sag_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.cap = s_valid;
            end
            sag_pkg::ST_COUNT: begin
                cmd.cnt = 1'b1;
            end
            sag_pkg::ST_CHECK: begin
                cmd.init_walk = 1'b1;
            end
            sag_pkg::ST_FLAG: begin
                cmd.flag = sts.out_free;
            end
            sag_pkg::ST_WALK: begin
                cmd.step = sts.skip || sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/sag_dp.sv @@
// ----------------------------------------------------------------------------
// sag_dp: datapath of the stencil address generator
// Holds the request, counts the stencil points, walks the row and column
// offsets, also over an excluded centre, and drives the output register.
// ----------------------------------------------------------------------------
module sag_dp #(
    parameter int MAX_POINTS = sag_pkg::MAX_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [sag_pkg::ADDR_W-1:0]      s_base_addr,
    input  logic [sag_pkg::KIND_W-1:0]      s_nbhd_kind,
    input  logic                            s_center_incl,
    input  logic [sag_pkg::RADIUS_W-1:0]    s_radius,
    input  logic [sag_pkg::ROWW_W-1:0]      s_row_width,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sag_pkg::ADDR_W-1:0]      m_elem_addr,
    output logic [sag_pkg::STATUS_W-1:0]    m_status,
    output logic                            m_last,
    input  sag_pkg::cmd_t                   cmd,
    output sag_pkg::sts_t                   sts
);

    localparam int PL_W = $clog2(MAX_POINTS + 1);
    localparam logic [sag_pkg::ADDR_W-1:0] ADDR_MASK =
        (sag_pkg::ADDR_BITS >= sag_pkg::ADDR_W) ? {sag_pkg::ADDR_W{1'b1}}
        : sag_pkg::ADDR_W'((64'd1 << sag_pkg::ADDR_BITS) - 64'd1);

    // Held request
    logic [sag_pkg::ADDR_W-1:0]   base_reg;
    logic [sag_pkg::KIND_W-1:0]   kind_reg;
    logic                         cin_reg;
    logic [sag_pkg::RADIUS_W-1:0] radius_reg;
    logic [sag_pkg::ROWW_W-1:0]   roww_reg;

    // Count and walk state
    logic [sag_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PL_W-1:0]                  pl_reg;
    logic signed [sag_pkg::OFF_W-1:0] row_off_reg, col_off_reg;
    logic signed [sag_pkg::OFF_W-1:0] row_inc;

    // Output register
    logic                          m_valid_reg;
    logic [sag_pkg::ADDR_W-1:0]    elem_addr_reg;
    logic [sag_pkg::STATUS_W-1:0]  status_reg;
    logic                          last_reg;

    logic [12:0]                   rr1;
    logic [sag_pkg::OFF_W-1:0]     half_cur, half_nxt, half_first;
    logic signed [23:0]            jw;
    logic [sag_pkg::ADDR_W-1:0]    addr_sum;
    logic                          emit;

    // Half width of the column range on a given row
    function automatic logic [sag_pkg::OFF_W-1:0] half_span(
        input logic [sag_pkg::KIND_W-1:0]   kind,
        input logic [sag_pkg::RADIUS_W-1:0] r,
        input logic signed [sag_pkg::OFF_W-1:0] ii
    );
        logic [sag_pkg::OFF_W-1:0] r_ext;
        logic [sag_pkg::OFF_W-1:0] ai;
        begin
            r_ext = {1'b0, r};
            ai    = ii[sag_pkg::OFF_W-1] ? sag_pkg::OFF_W'(-ii) : sag_pkg::OFF_W'(ii);
            case (kind)
                sag_pkg::KIND_VON_NEUMANN: half_span = r_ext - ai;
                sag_pkg::KIND_MOORE:       half_span = r_ext;
                sag_pkg::KIND_CROSS:       half_span = (ii == '0) ? r_ext : '0;
                default:                   half_span = '0;
            endcase
        end
    endfunction

    // Point count: r(r+1) serves both the diamond and the square
    always_comb begin
        rr1 = 13'(radius_reg) * 13'({1'b0, radius_reg} + 7'd1);
        case (kind_reg)
            sag_pkg::KIND_VON_NEUMANN:
                cnt_next = sag_pkg::CNT_W'({rr1, 1'b0}) + sag_pkg::CNT_W'(cin_reg);
            sag_pkg::KIND_MOORE:
                cnt_next = sag_pkg::CNT_W'({rr1, 2'b00}) + sag_pkg::CNT_W'(cin_reg);
            sag_pkg::KIND_CROSS:
                cnt_next = sag_pkg::CNT_W'({radius_reg, 2'b00}) + sag_pkg::CNT_W'(cin_reg);
            default:
                cnt_next = '0;
        endcase
    end

    // Column ranges of the current, next and first rows
    assign row_inc    = row_off_reg + sag_pkg::OFF_W'(1);
    assign half_cur   = half_span(kind_reg, radius_reg, row_off_reg);
    assign half_nxt   = half_span(kind_reg, radius_reg, row_inc);
    assign half_first = half_span(kind_reg, radius_reg,
                                  -$signed({1'b0, radius_reg}));

    // Address of the current offset, wrapped to the address space
    always_comb begin
        jw       = 24'(col_off_reg) * 24'($signed({1'b0, roww_reg}));
        addr_sum = base_reg
                 + {{(sag_pkg::ADDR_W - sag_pkg::OFF_W - 2){row_off_reg[sag_pkg::OFF_W-1]}},
                    row_off_reg, 2'b00}
                 + {{(sag_pkg::ADDR_W - 26){jw[23]}}, jw, 2'b00};
    end

    // Status towards the controller
    always_comb begin
        sts.over     = cnt_reg > sag_pkg::CNT_W'(MAX_POINTS);
        sts.zero     = cnt_reg == '0;
        sts.out_free = !m_valid_reg || m_ready;
        sts.skip     = (row_off_reg == '0) && (col_off_reg == '0) && !cin_reg;
        sts.last_pt  = pl_reg == PL_W'(1);
    end

    assign emit = cmd.step && !sts.skip;

    // Capture the request and the count
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            base_reg   <= s_base_addr;
            kind_reg   <= s_nbhd_kind;
            cin_reg    <= s_center_incl;
            radius_reg <= s_radius;
            roww_reg   <= s_row_width;
        end
        if (cmd.cnt) begin
            cnt_reg <= cnt_next;
        end
    end

    // Walk the offsets: advance the column, or move to the next row
    always_ff @(posedge aclk) begin
        if (cmd.init_walk) begin
            row_off_reg <= -$signed({1'b0, radius_reg});
            col_off_reg <= -$signed(half_first);
        end else if (cmd.step) begin
            if (col_off_reg == $signed(half_cur)) begin
                row_off_reg <= row_inc;
                col_off_reg <= -$signed(half_nxt);
            end else begin
                col_off_reg <= col_off_reg + sag_pkg::OFF_W'(1);
            end
        end
    end

    // Count down the points still to emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pl_reg <= '0;
        end else if (cmd.init_walk) begin
            pl_reg <= cnt_reg[PL_W-1:0];
        end else if (emit) begin
            pl_reg <= pl_reg - PL_W'(1);
        end
    end

    // Output register: load a word, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit || cmd.flag) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            elem_addr_reg <= addr_sum & ADDR_MASK;
            status_reg    <= sag_pkg::STATUS_OK;
            last_reg      <= sts.last_pt;
        end else if (cmd.flag) begin
            elem_addr_reg <= '0;
            status_reg    <= sts.over ? sag_pkg::STATUS_TOO_MANY : sag_pkg::STATUS_EMPTY;
            last_reg      <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_elem_addr = elem_addr_reg;
    assign m_status    = status_reg;
    assign m_last      = last_reg;

`ifndef NO_ASSERTIONS
    // A word is only loaded when the output register can take it
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit || cmd.flag) |-> sts.out_free)
        else $error("word loaded into a full output register");

    // Emitting the final point empties the count
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && sts.last_pt) |=> (pl_reg == '0))
        else $error("points left not cleared after the final point");

    // Only walk words can be followed by more words of the request
    a_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !last_reg) |-> (status_reg == sag_pkg::STATUS_OK))
        else $error("flag word without last mark");

    // The walk never emits more points than were counted
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (pl_reg != '0))
        else $error("point emitted with none left");
`endif

endmodule
